FILE: rtl/sbh_pkg.sv
// shared types, constants and round functions of the sha-256 byte stream hasher
package sbh_pkg;

	localparam int BlockBytes   = 64;
	localparam int BlockWords   = BlockBytes / 4;
	localparam int NumRounds    = 64;
	localparam int LengthOffset = 56;
	localparam int DigestWords  = 8;

	localparam logic [7:0] PadMark = 8'h80;

	typedef logic [DigestWords-1:0][31:0] wv_t;

	localparam wv_t InitChain = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	// schedule inputs for one round
	typedef struct packed {
		logic        use_mem;
		logic [31:0] w_mem;
		logic [31:0] w16;
		logic [31:0] w15;
		logic [31:0] w7;
		logic [31:0] w2;
	} sched_taps_t;

	function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] sig0(input logic [31:0] x);
		return ror32(x, 7) ^ ror32(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] sig1(input logic [31:0] x);
		return ror32(x, 17) ^ ror32(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] ep0(input logic [31:0] x);
		return ror32(x, 2) ^ ror32(x, 13) ^ ror32(x, 22);
	endfunction

	function automatic logic [31:0] ep1(input logic [31:0] x);
		return ror32(x, 6) ^ ror32(x, 11) ^ ror32(x, 25);
	endfunction

	function automatic logic [31:0] round_k(input logic [5:0] r);
		logic [31:0] k;
		case (r)
			6'd0:  k = 32'h428a2f98;
			6'd1:  k = 32'h71374491;
			6'd2:  k = 32'hb5c0fbcf;
			6'd3:  k = 32'he9b5dba5;
			6'd4:  k = 32'h3956c25b;
			6'd5:  k = 32'h59f111f1;
			6'd6:  k = 32'h923f82a4;
			6'd7:  k = 32'hab1c5ed5;
			6'd8:  k = 32'hd807aa98;
			6'd9:  k = 32'h12835b01;
			6'd10: k = 32'h243185be;
			6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74;
			6'd13: k = 32'h80deb1fe;
			6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174;
			6'd16: k = 32'he49b69c1;
			6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6;
			6'd19: k = 32'h240ca1cc;
			6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa;
			6'd22: k = 32'h5cb0a9dc;
			6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152;
			6'd25: k = 32'ha831c66d;
			6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7;
			6'd28: k = 32'hc6e00bf3;
			6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351;
			6'd31: k = 32'h14292967;
			6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138;
			6'd34: k = 32'h4d2c6dfc;
			6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354;
			6'd37: k = 32'h766a0abb;
			6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85;
			6'd40: k = 32'ha2bfe8a1;
			6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70;
			6'd43: k = 32'hc76c51a3;
			6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624;
			6'd46: k = 32'hf40e3585;
			6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116;
			6'd49: k = 32'h1e376c08;
			6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5;
			6'd52: k = 32'h391c0cb3;
			6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f;
			6'd55: k = 32'h682e6ff3;
			6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f;
			6'd58: k = 32'h84c87814;
			6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa;
			6'd61: k = 32'ha4506ceb;
			6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

endpackage

FILE: rtl/sbh_intf.sv
// handshake channels of the sha-256 byte stream hasher
interface sbh_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       end_of_message;

	modport source(output valid, data_byte, has_byte, end_of_message, input ready);
	modport sink(input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sbh_digest_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;

	modport source(output valid, digest_word, word_index, last_word, input ready);
	modport sink(input valid, digest_word, word_index, last_word, output ready);
endinterface

FILE: rtl/sbh_round.sv
// one sha-256 round: message schedule word and working variable update
module sbh_round import sbh_pkg::*; (
	input  wv_t         wv,
	input  sched_taps_t taps,
	input  logic [31:0] k,
	output logic [31:0] sched,
	output wv_t         wv_next
);

	logic [31:0] sum1;
	logic [31:0] sum2;
	logic [31:0] choose;
	logic [31:0] major;

	always_comb begin
		if (taps.use_mem) begin
			sched = taps.w_mem;
		end else begin
			sched = taps.w16 + sig0(taps.w15) + taps.w7 + sig1(taps.w2);
		end
		choose = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
		major  = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
		sum1   = wv[7] + ep1(wv[4]) + choose + k + sched;
		sum2   = ep0(wv[0]) + major;
		wv_next    = wv;
		wv_next[7] = wv[6];
		wv_next[6] = wv[5];
		wv_next[5] = wv[4];
		wv_next[4] = wv[3] + sum1;
		wv_next[3] = wv[2];
		wv_next[2] = wv[1];
		wv_next[1] = wv[0];
		wv_next[0] = sum1 + sum2;
	end

endmodule

FILE: rtl/sha256_byte_stream_hasher.sv
// sha-256 hasher over a byte stream: block buffer memory, round engine, digest output
//
// msg channel: one word per handshake, carrying data_byte, has_byte and
// end_of_message. a word with has_byte set appends its byte; a word with
// end_of_message set closes the message (after its byte, if any). an end with
// no byte at all gives the digest of the empty message.
// digest channel: eight 32-bit digest words per message, most significant
// first, word_index counting 0..7 and last_word set on the eighth.
// a byte that does not complete a 64-byte block is taken without a stall;
// the 64th byte starts a compression (a load step, 64 rounds of the single
// round unit, a fold into the chaining value), during which msg.ready is
// low. the end of a message appends the padding bytes (9 to 72 bytes) with
// one or two compressions, then hands out the digest words.
// after reset the chaining value holds the initial hash, length and fill are
// zero and the block takes bytes at once; after each digest it returns there.
// the digest words sit in an output register: a stalled receiver holds the
// block only when the next digest is ready to be handed over.
module sha256_byte_stream_hasher import sbh_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	sbh_msg_if.sink      msg,
	sbh_digest_if.source digest
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_ROUND,
		ST_FOLD,
		ST_OUT
	} state_t;

	state_t      state_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oidx_q;
	logic        end_pend_q;
	logic        mark_q;
	logic        wrap_q;
	logic        fin_q;
	wv_t         chain_q;
	logic        out_valid_q;
	logic [31:0] out_word_q;
	logic [2:0]  out_index_q;
	logic        out_last_q;

	// block buffer, later reused as nothing else: the schedule lives in win_q
	logic [31:0] buf_mem [BlockWords];
	logic [31:0] rd_s1;
	logic [23:0] acc_q;
	logic [31:0] win_q [BlockWords];
	wv_t         wv_q;

	logic        msg_acc;
	logic        push_en;
	logic [7:0]  push_byte;
	logic [7:0]  pad_byte;
	logic [2:0]  len_sel;
	logic [7:0]  len_byte;
	logic [3:0]  rd_addr;
	logic        out_free;
	sched_taps_t taps;
	logic [31:0] sched;
	wv_t         wv_next;

	assign msg.ready = (state_q == ST_IDLE);
	assign msg_acc   = msg.valid && msg.ready;

	// length bytes go out big-endian at offsets 56..63
	assign len_sel  = ~fill_q[2:0];
	assign len_byte = len_q[{len_sel, 3'b000} +: 8];

	always_comb begin
		if (!mark_q) begin
			pad_byte = PadMark;
		end else if (!wrap_q && (fill_q >= 6'(LengthOffset))) begin
			pad_byte = len_byte;
		end else begin
			pad_byte = 8'h00;
		end
	end

	assign push_en   = (msg_acc && msg.has_byte) || (state_q == ST_PAD);
	assign push_byte = (state_q == ST_PAD) ? pad_byte : msg.data_byte;

	assign rd_addr  = (state_q == ST_ROUND) ? (rnd_q[3:0] + 4'd1) : 4'd0;
	assign out_free = !out_valid_q || digest.ready;

	assign taps.use_mem = (rnd_q < 6'(BlockWords));
	assign taps.w_mem   = rd_s1;
	assign taps.w16     = win_q[0];
	assign taps.w15     = win_q[1];
	assign taps.w7      = win_q[9];
	assign taps.w2      = win_q[14];

	sbh_round u_round (
		.wv      (wv_q),
		.taps    (taps),
		.k       (round_k(rnd_q)),
		.sched   (sched),
		.wv_next (wv_next)
	);

	// buffer memory, schedule window and working variables
	always_ff @(posedge clk) begin
		rd_s1 <= buf_mem[rd_addr];
		if (push_en) begin
			acc_q <= {acc_q[15:0], push_byte};
			if (fill_q[1:0] == 2'd3) begin
				buf_mem[fill_q[5:2]] <= {acc_q, push_byte};
			end
		end
		if (state_q == ST_LOAD) begin
			wv_q <= chain_q;
		end else if (state_q == ST_ROUND) begin
			wv_q <= wv_next;
			for (int i = 0; i < BlockWords - 1; i++) begin
				win_q[i] <= win_q[i+1];
			end
			win_q[BlockWords-1] <= sched;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			len_q       <= '0;
			rnd_q       <= '0;
			oidx_q      <= '0;
			end_pend_q  <= 1'b0;
			mark_q      <= 1'b0;
			wrap_q      <= 1'b0;
			fin_q       <= 1'b0;
			chain_q     <= InitChain;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_index_q <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (digest.ready) begin
				out_valid_q <= 1'b0;
			end
			if (push_en) begin
				fill_q <= fill_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						end_pend_q <= msg.end_of_message;
						if (msg.has_byte) begin
							len_q <= len_q + 64'd8;
						end
						if (msg.has_byte && (fill_q == 6'(BlockBytes - 1))) begin
							state_q <= ST_LOAD;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
						// mark at or past the length offset: this block is zero-filled, a further block holds the length
						wrap_q <= (fill_q >= 6'(LengthOffset));
					end else if (!wrap_q && (fill_q == 6'(BlockBytes - 1))) begin
						fin_q <= 1'b1;
					end
					if (fill_q == 6'(BlockBytes - 1)) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					rnd_q   <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'(NumRounds - 1)) begin
						state_q <= ST_FOLD;
					end
				end
				ST_FOLD: begin
					for (int i = 0; i < DigestWords; i++) begin
						chain_q[i] <= chain_q[i] + wv_q[i];
					end
					wrap_q <= 1'b0;
					oidx_q <= '0;
					if (fin_q) begin
						state_q <= ST_OUT;
					end else if (end_pend_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						out_word_q  <= chain_q[oidx_q];
						out_index_q <= oidx_q;
						out_last_q  <= (oidx_q == 3'(DigestWords - 1));
						oidx_q      <= oidx_q + 3'd1;
						if (oidx_q == 3'(DigestWords - 1)) begin
							chain_q    <= InitChain;
							len_q      <= '0;
							end_pend_q <= 1'b0;
							mark_q     <= 1'b0;
							fin_q      <= 1'b0;
							state_q    <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign digest.valid       = out_valid_q;
	assign digest.digest_word = out_word_q;
	assign digest.word_index  = out_index_q;
	assign digest.last_word   = out_last_q;

	a_round_to_fold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROUND) && (rnd_q == 6'(NumRounds - 1)) |=> (state_q == ST_FOLD))
		else $error("compression did not end after the last round");

	a_out_fill_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT) |-> (fill_q == '0))
		else $error("digest output with a partly filled block");

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		digest.valid && digest.last_word |-> (digest.word_index == 3'(DigestWords - 1)))
		else $error("last digest word at wrong index");

	a_end_pending: assert property (@(posedge clk) disable iff (!arst_n)
		msg_acc && msg.end_of_message |=> end_pend_q)
		else $error("end of message not recorded");

	a_fin_needs_mark: assert property (@(posedge clk) disable iff (!arst_n)
		fin_q |-> mark_q)
		else $error("final block flagged before the pad mark");

endmodule

FILE: verif/testbench.sv
// self-checking testbench of the sha-256 byte stream hasher
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sbh_pkg::*;

	localparam int CycleLimit   = 400000;
	localparam int DrainCycles  = 300;
	localparam int ItemsPerPhase = 120;
	localparam int NumPhases    = 3;

	localparam logic [31:0] RoundConst [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	typedef struct {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} digest_entry_t;

	class sha256_tracker;
		logic [31:0]   chain [8];
		logic [7:0]    blk_bytes [64];
		int            fill;
		logic [63:0]   bit_count;
		digest_entry_t digest_queue [$];
		int            mismatch_count;
		int            words_checked;
		int            messages_hashed;
		int            bytes_hashed;

		function new();
			restart();
			mismatch_count  = 0;
			words_checked   = 0;
			messages_hashed = 0;
			bytes_hashed    = 0;
		endfunction

		function void restart();
			for (int j = 0; j < 8; j++)
				chain[j] = InitChain[j];
			fill      = 0;
			bit_count = '0;
		endfunction

		function logic [31:0] rotr(input logic [31:0] x, input int n);
			logic [63:0] twice;
			twice = {x, x} >> n;
			return twice[31:0];
		endfunction

		function void compress_block();
			logic [31:0] w [64];
			logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
			for (int r = 0; r < 16; r++)
				w[r] = {blk_bytes[4*r], blk_bytes[4*r+1], blk_bytes[4*r+2], blk_bytes[4*r+3]};
			for (int r = 16; r < 64; r++) begin
				s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
				s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
				w[r] = w[r-16] + s0 + w[r-7] + s1;
			end
			a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
			e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
			for (int r = 0; r < 64; r++) begin
				t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
					+ RoundConst[r] + w[r];
				t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
				h = g; g = f; f = e; e = d + t1;
				d = c; c = b; b = a; a = t1 + t2;
			end
			chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
			chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
		endfunction

		function void append_byte(input logic [7:0] value);
			blk_bytes[fill] = value;
			fill++;
			if (fill == 64) begin
				compress_block();
				fill = 0;
			end
		endfunction

		// called for every accepted msg word
		function void note_word(input logic [7:0] data, input logic has, input logic eom);
			digest_entry_t ent;
			if (has) begin
				append_byte(data);
				bit_count += 64'd8;
				bytes_hashed++;
			end
			if (!eom)
				return;
			append_byte(PadMark);
			while (fill != LengthOffset)
				append_byte(8'h00);
			for (int k = 0; k < 8; k++)
				append_byte(bit_count[63-8*k -: 8]);
			for (int k = 0; k < 8; k++) begin
				ent.digest_word = chain[k];
				ent.word_index  = 3'(k);
				ent.last_word   = (k == 7);
				digest_queue = {digest_queue, ent};
			end
			messages_hashed++;
			restart();
		endfunction

		function void check_word(input logic [31:0] word, input logic [2:0] idx, input logic last);
			digest_entry_t ent;
			if (digest_queue.size() == 0) begin
				$error("digest word %h arrived with nothing outstanding", word);
				mismatch_count++;
				return;
			end
			ent = digest_queue.pop_front();
			words_checked++;
			if (word !== ent.digest_word) begin
				$error("digest_word expected %h got %h", ent.digest_word, word);
				mismatch_count++;
			end
			if (idx !== ent.word_index) begin
				$error("word_index expected %0d got %0d", ent.word_index, idx);
				mismatch_count++;
			end
			if (last !== ent.last_word) begin
				$error("last_word expected %b got %b", ent.last_word, last);
				mismatch_count++;
			end
		endfunction

		function int outstanding();
			return digest_queue.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_idle_pct;
	int   cycle_count;
	int   items_sent;

	sha256_tracker sb;

	sbh_msg_if    msg_ch ();
	sbh_digest_if dig_ch ();

	sha256_byte_stream_hasher dut (
		.clk    (clk),
		.arst_n (arst_n),
		.msg    (msg_ch),
		.digest (dig_ch)
	);

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver: random stalls, checked at the rising edge
	always @(negedge clk) begin
		dig_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && dig_ch.valid && dig_ch.ready)
			sb.check_word(dig_ch.digest_word, dig_ch.word_index, dig_ch.last_word);
	end

	// one msg word; called at a falling edge and returns at a falling edge
	task automatic send_word(input logic [7:0] data, input logic has, input logic eom);
		while ($urandom_range(99) < send_idle_pct) begin
			msg_ch.valid          <= 1'b0;
			msg_ch.data_byte      <= 8'($urandom);
			msg_ch.has_byte       <= 1'($urandom);
			msg_ch.end_of_message <= 1'($urandom);
			@(negedge clk);
		end
		msg_ch.valid          <= 1'b1;
		msg_ch.data_byte      <= data;
		msg_ch.has_byte       <= has;
		msg_ch.end_of_message <= eom;
		do
			@(posedge clk);
		while (!msg_ch.ready);
		sb.note_word(data, has, eom);
		if (has || eom)
			items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_until_drained();
		msg_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
	endtask

	task automatic send_message(input int len);
		bit tail_has_byte;
		tail_has_byte = (len > 0) && $urandom_range(1);
		for (int i = 0; i < len; i++) begin
			// occasional word that carries nothing
			if ($urandom_range(99) < 6)
				send_word(8'($urandom), 1'b0, 1'b0);
			if (tail_has_byte && i == len - 1)
				send_word(8'($urandom), 1'b1, 1'b1);
			else
				send_word(8'($urandom), 1'b1, 1'b0);
		end
		if (!tail_has_byte)
			send_word(8'($urandom), 1'b0, 1'b1);
	endtask

	function automatic int pick_length();
		int r;
		int edges [6] = '{55, 56, 57, 63, 64, 65};
		r = $urandom_range(99);
		if (r < 40)
			return $urandom_range(8, 0);
		if (r < 65)
			return $urandom_range(54, 9);
		if (r < 82)
			return edges[$urandom_range(5)];
		if (r < 92)
			return $urandom_range(128, 100);
		return 0;
	endfunction

	initial begin
		sb            = new();
		cycle_count   = 0;
		items_sent    = 0;
		send_idle_pct = 11;
		recv_idle_pct = 62;
		arst_n        = 1'b0;
		msg_ch.valid          = 1'b0;
		msg_ch.data_byte      = 8'h00;
		msg_ch.has_byte       = 1'b0;
		msg_ch.end_of_message = 1'b0;
		dig_ch.ready          = 1'b0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// empty message, then a word that carries nothing
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hff, 1'b0, 1'b0);
		// byte and end together
		send_word(8'hff, 1'b1, 1'b1);
		// "abc" closed by an end with no byte
		send_word(8'h61, 1'b1, 1'b0);
		send_word(8'h62, 1'b1, 1'b0);
		send_word(8'h63, 1'b1, 1'b0);
		send_word(8'ha5, 1'b0, 1'b1);
		// empty word in the middle of a message
		send_word(8'h00, 1'b1, 1'b0);
		send_word(8'h3c, 1'b0, 1'b0);
		send_word(8'h80, 1'b1, 1'b0);
		send_word(8'h7f, 1'b1, 1'b1);
		// two empty messages back to back
		send_word(8'h00, 1'b0, 1'b1);
		send_word(8'hff, 1'b0, 1'b1);
		wait_until_drained();
		@(negedge clk);
		items_sent = 0;

		for (int phase = 0; phase < NumPhases; phase++) begin
			case (phase)
				0: begin send_idle_pct = 11; recv_idle_pct = 62; end
				1: begin send_idle_pct = 62; recv_idle_pct = 11; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			while (items_sent < ItemsPerPhase * (phase + 1) ||
					(phase == NumPhases - 1 && sb.messages_hashed < 16)) begin
				if ($urandom_range(99) < 5) begin
					wait_until_drained();
					@(negedge clk);
				end
				send_message(pick_length());
			end
			// sender holds off until every digest of the phase is out
			wait_until_drained();
			@(negedge clk);
		end

		msg_ch.valid <= 1'b0;
		while (sb.outstanding() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);

		$display("hashed %0d messages, %0d message bytes, %0d digest words checked",
			sb.messages_hashed, sb.bytes_hashed, sb.words_checked);
		$display("covered empty, single-block and multi-block messages under stalls on both sides");
		if (sb.mismatch_count == 0 && sb.outstanding() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			if (sb.outstanding() != 0)
				$error("%0d digest words never arrived", sb.outstanding());
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

FILE: files.f
rtl/sbh_pkg.sv
rtl/sbh_intf.sv
rtl/sbh_round.sv
rtl/sha256_byte_stream_hasher.sv
verif/testbench.sv
